// ----- sv/sia_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot index allocator package
// Widths, sizes, codes and the structs passed between the allocator modules.
// ----------------------------------------------------------------------------
package sia_pkg;

    localparam int INDEX_W          = 12;
    localparam int COUNT_W          = 13;
    localparam int INITIAL_CAPACITY = 1024;
    localparam int MAX_CAPACITY     = 4096;
    localparam int STACK_DEPTH      = 4096;
    localparam int ADDR_W           = $clog2(STACK_DEPTH);

    typedef enum logic
    {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        STATUS_OK        = 2'd0,
        STATUS_GREW      = 2'd1,
        STATUS_EXHAUSTED = 2'd2,
        STATUS_OVERFLOW  = 2'd3
    } status_t;

    typedef struct packed
    {
        logic                push;
        logic                pop;
        logic [ADDR_W-1:0]   addr;
        logic [INDEX_W-1:0]  data;
    } stack_cmd_t;

    typedef struct packed
    {
        logic                pop;
        status_t             status;
        logic [INDEX_W-1:0]  index;
        logic [INDEX_W-1:0]  grow;
    } decision_t;

endpackage

// ----- sv/sia_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Carries acquire and release transactions into the allocator.
// ----------------------------------------------------------------------------
interface sia_req_if;

    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [sia_pkg::INDEX_W-1:0] slot_index;

    modport source (output valid, output operation, output slot_index, input ready);
    modport sink   (input valid, input operation, input slot_index, output ready);

endinterface

// ----- sv/sia_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Carries one result transaction per request out of the allocator.
// ----------------------------------------------------------------------------
interface sia_rsp_if;

    logic                        valid;
    logic                        ready;
    logic [sia_pkg::INDEX_W-1:0] granted_index;
    logic [1:0]                  status;
    logic [sia_pkg::INDEX_W-1:0] grow_amount;

    modport source (output valid, output granted_index, output status, output grow_amount,
                    input ready);
    modport sink   (input valid, input granted_index, input status, input grow_amount,
                    output ready);

endinterface

// ----- sv/slot_index_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot index allocator
// Hands out slot indices from a growing table and takes them back on a stack.
// ----------------------------------------------------------------------------
// A request transaction on req is either an acquire or a release. Every
// request yields exactly one response transaction on rsp, in order.
// An acquire is granted a never-used index first, then the most recently
// released one, and otherwise the table doubles; past the maximum it reports
// exhausted. A release is pushed onto the freed stack, or reported as an
// overflow when the stack holds min(capacity, stack depth) indices.
// A request passes through the decision register, written together with
// the registered stack read, and then the response register. One
// transaction can be taken every cycle while rsp.ready is high; the stack
// is a single-port memory used at most once per request.
// After reset the capacity is 1024, all of it never used, and the freed
// stack is empty; the block can take requests in the first cycle.
// When rsp.ready is low, the response register holds its transaction and
// one more decided request waits behind it; req.ready then drops.
// ----------------------------------------------------------------------------
module slot_index_allocator
(
    input  logic       clk,
    input  logic       rst_n,
    sia_req_if.sink    req,
    sia_rsp_if.source  rsp
);

    sia_pkg::stack_cmd_t         cmd;
    sia_pkg::decision_t          dec;
    logic                        dec_valid;
    logic [sia_pkg::INDEX_W-1:0] rdata;
    logic                        advance;
    logic                        take;

    logic                        rsp_valid_reg;
    logic [sia_pkg::INDEX_W-1:0] granted_reg;
    logic [1:0]                  status_reg;
    logic [sia_pkg::INDEX_W-1:0] grow_reg;

    assign advance   = !rsp_valid_reg || rsp.ready;
    assign req.ready = !dec_valid || advance;
    assign take      = req.valid && req.ready;

    sia_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .advance    (advance),
        .operation  (req.operation),
        .slot_index (req.slot_index),
        .cmd        (cmd),
        .dec        (dec),
        .dec_valid  (dec_valid)
    );

    sia_stack u_stack
    (
        .clk   (clk),
        .cmd   (cmd),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= dec_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && dec_valid)
        begin
            granted_reg <= dec.pop ? rdata : dec.index;
            status_reg  <= dec.status;
            grow_reg    <= dec.grow;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.granted_index = granted_reg;
    assign rsp.status        = status_reg;
    assign rsp.grow_amount   = grow_reg;

endmodule

// ----- sv/sia_stack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Freed index stack
// Single-port memory holding released indices, with a registered read port.
// ----------------------------------------------------------------------------
module sia_stack
(
    input  logic                          clk,
    input  sia_pkg::stack_cmd_t           cmd,
    output logic [sia_pkg::INDEX_W-1:0]   rdata
);

    logic [sia_pkg::INDEX_W-1:0] mem [sia_pkg::STACK_DEPTH];
    logic [sia_pkg::INDEX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[cmd.addr] <= cmd.data;
        end
        if (cmd.pop)
        begin
            rdata_reg <= mem[cmd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/sia_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator control
// Holds the capacity and the counters, decides each transaction and drives the stack.
// ----------------------------------------------------------------------------
module sia_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic                          advance,
    input  logic                          operation,
    input  logic [sia_pkg::INDEX_W-1:0]   slot_index,
    output sia_pkg::stack_cmd_t           cmd,
    output sia_pkg::decision_t            dec,
    output logic                          dec_valid
);

    logic [sia_pkg::COUNT_W-1:0] capacity_reg, capacity_next;
    logic [sia_pkg::COUNT_W-1:0] unused_reg, unused_next;
    logic [sia_pkg::COUNT_W-1:0] freed_reg, freed_next;
    logic                        dec_valid_reg, dec_valid_next;
    sia_pkg::decision_t          dec_reg, dec_next;
    logic [sia_pkg::COUNT_W-1:0] stack_limit;
    logic [sia_pkg::COUNT_W-1:0] next_fresh;
    logic [sia_pkg::COUNT_W-1:0] top;
    logic [sia_pkg::COUNT_W:0]   grown;

    always_comb
    begin
        stack_limit = (capacity_reg < sia_pkg::COUNT_W'(sia_pkg::STACK_DEPTH)) ?
                      capacity_reg : sia_pkg::COUNT_W'(sia_pkg::STACK_DEPTH);
        next_fresh  = capacity_reg - unused_reg;
        top         = freed_reg - 1'b1;
        grown       = {capacity_reg, 1'b0};

        capacity_next  = capacity_reg;
        unused_next    = unused_reg;
        freed_next     = freed_reg;
        dec_next       = dec_reg;
        dec_valid_next = dec_valid_reg;
        cmd            = '0;

        if (advance)
        begin
            dec_valid_next = 1'b0;
        end

        if (take)
        begin
            dec_valid_next = 1'b1;
            dec_next       = '0;
            dec_next.status = sia_pkg::STATUS_OK;
            if (operation == sia_pkg::OP_RELEASE)
            begin
                if (freed_reg >= stack_limit)
                begin
                    dec_next.status = sia_pkg::STATUS_OVERFLOW;
                end
                else
                begin
                    cmd.push   = 1'b1;
                    cmd.addr   = freed_reg[sia_pkg::ADDR_W-1:0];
                    cmd.data   = slot_index;
                    freed_next = freed_reg + 1'b1;
                end
            end
            else if (unused_reg != '0)
            begin
                dec_next.index = next_fresh[sia_pkg::INDEX_W-1:0];
                unused_next    = unused_reg - 1'b1;
            end
            else if (freed_reg != '0)
            begin
                cmd.pop      = 1'b1;
                cmd.addr     = top[sia_pkg::ADDR_W-1:0];
                dec_next.pop = 1'b1;
                freed_next   = top;
            end
            else if (grown > (sia_pkg::COUNT_W+1)'(sia_pkg::MAX_CAPACITY))
            begin
                dec_next.status = sia_pkg::STATUS_EXHAUSTED;
            end
            else
            begin
                dec_next.status = sia_pkg::STATUS_GREW;
                dec_next.index  = capacity_reg[sia_pkg::INDEX_W-1:0];
                dec_next.grow   = capacity_reg[sia_pkg::INDEX_W-1:0];
                unused_next     = capacity_reg - 1'b1;
                capacity_next   = grown[sia_pkg::COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= sia_pkg::COUNT_W'(sia_pkg::INITIAL_CAPACITY);
            unused_reg    <= sia_pkg::COUNT_W'(sia_pkg::INITIAL_CAPACITY);
            freed_reg     <= '0;
            dec_valid_reg <= 1'b0;
        end
        else
        begin
            capacity_reg  <= capacity_next;
            unused_reg    <= unused_next;
            freed_reg     <= freed_next;
            dec_valid_reg <= dec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dec_reg <= dec_next;
    end

    assign dec       = dec_reg;
    assign dec_valid = dec_valid_reg;

endmodule
